// ===== rtl/core/yuvrgb_pkg.sv =====
// Package: shared types, constants and arithmetic helpers for the YUV 4:2:2 to RGB888 converter
package yuvrgb_pkg;

    // Byte packing codes held in the order register
    localparam logic [2:0] ORDER_YUYV = 3'd0;
    localparam logic [2:0] ORDER_UYVY = 3'd1;
    localparam logic [2:0] ORDER_VYUY = 3'd2;
    localparam logic [2:0] ORDER_YVYU = 3'd3;
    localparam logic [2:0] ORDER_UVY2 = 3'd4;
    localparam logic [2:0] ORDER_VUY2 = 3'd5;
    localparam logic [2:0] ORDER_Y2UV = 3'd6;
    localparam logic [2:0] ORDER_Y2VU = 3'd7;

    localparam int unsigned FRAC_SHIFT = 20;
    localparam int unsigned TERM_W     = 29;   // widest clamped term is below 2^29
    localparam int unsigned SUM_W      = TERM_W + 1;

    localparam logic signed [31:0] COEF_Y  = 32'sd1220542;
    localparam logic signed [31:0] COEF_VR = 32'sd1673527;
    localparam logic signed [31:0] COEF_VG = -32'sd852492;
    localparam logic signed [31:0] COEF_UG = -32'sd409993;
    localparam logic signed [31:0] COEF_UB = 32'sd2116026;

    localparam logic signed [31:0] LUMA_OFFSET   = 32'sd16;
    localparam logic signed [31:0] CHROMA_OFFSET = 32'sd128;
    localparam logic [SUM_W-FRAC_SHIFT-1:0] CHAN_MAX = 10'd255;

    typedef logic [7:0] byte_t;
    typedef byte_t [3:0] macro_t;

    // Byte positions of Y0, Y1, U and V within the macropixel
    typedef struct packed {
        logic [1:0] y0;
        logic [1:0] y1;
        logic [1:0] u;
        logic [1:0] v;
    } pack_sel_t;

    typedef struct packed {
        byte_t red_first;
        byte_t green_first;
        byte_t blue_first;
        byte_t red_second;
        byte_t green_second;
        byte_t blue_second;
    } rgb_pair_t;

    function automatic pack_sel_t pack_map(input logic [2:0] mode);
        pack_sel_t sel;
        unique case (mode)
            ORDER_YUYV: sel = '{y0: 2'd0, y1: 2'd2, u: 2'd1, v: 2'd3};
            ORDER_UYVY: sel = '{y0: 2'd1, y1: 2'd3, u: 2'd0, v: 2'd2};
            ORDER_VYUY: sel = '{y0: 2'd1, y1: 2'd3, u: 2'd2, v: 2'd0};
            ORDER_YVYU: sel = '{y0: 2'd0, y1: 2'd2, u: 2'd3, v: 2'd1};
            ORDER_UVY2: sel = '{y0: 2'd3, y1: 2'd1, u: 2'd0, v: 2'd2};
            ORDER_VUY2: sel = '{y0: 2'd3, y1: 2'd1, u: 2'd2, v: 2'd0};
            ORDER_Y2UV: sel = '{y0: 2'd2, y1: 2'd0, u: 2'd1, v: 2'd3};
            ORDER_Y2VU: sel = '{y0: 2'd2, y1: 2'd0, u: 2'd3, v: 2'd1};
            default:    sel = '{y0: 2'd0, y1: 2'd2, u: 2'd1, v: 2'd3};
        endcase
        return sel;
    endfunction

    // Clamp a signed product below at zero
    function automatic logic [TERM_W-1:0] floor_zero(input logic signed [31:0] x);
        return (x < 0) ? '0 : x[TERM_W-1:0];
    endfunction

    // Add luma and chroma terms, drop the fraction, saturate at full scale
    function automatic byte_t make_channel(input logic [TERM_W-1:0] luma,
                                           input logic [TERM_W-1:0] chroma);
        logic [SUM_W-1:0]            sum;
        logic [SUM_W-FRAC_SHIFT-1:0] whole;
        sum   = {1'b0, luma} + {1'b0, chroma};
        whole = sum[SUM_W-1:FRAC_SHIFT];
        return (whole > CHAN_MAX) ? 8'hFF : whole[7:0];
    endfunction

endpackage

// ===== rtl/core/yuvrgb_if.sv =====
// Interfaces: packed macropixel input channel and RGB pixel pair output channel

interface yuvrgb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       last_in;

    modport source (output valid, byte0, byte1, byte2, byte3, last_in, input ready);
    modport sink   (input valid, byte0, byte1, byte2, byte3, last_in, output ready);
endinterface

interface yuvrgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       last_out;

    modport source (output valid, red_first, green_first, blue_first,
                    red_second, green_second, blue_second, last_out, input ready);
    modport sink   (input valid, red_first, green_first, blue_first,
                    red_second, green_second, blue_second, last_out, output ready);
endinterface

// ===== rtl/core/yuvrgb_csc.sv =====
// Colour space conversion datapath: unpack one macropixel and produce two RGB888 pixels
module yuvrgb_csc (
    input  yuvrgb_pkg::macro_t    macro,
    input  logic [2:0]            order_mode,
    output yuvrgb_pkg::rgb_pair_t rgb
);

    yuvrgb_pkg::pack_sel_t sel;
    yuvrgb_pkg::byte_t     y0, y1, u, v;
    logic signed [31:0]    y0_d, y1_d, u_d, v_d;
    logic signed [31:0]    y0_p, y1_p, vr_p, g_p, ub_p;
    logic [yuvrgb_pkg::TERM_W-1:0] y0_t, y1_t, r_t, g_t, b_t;

    always_comb
    begin
        sel = yuvrgb_pkg::pack_map(order_mode);
        y0  = macro[sel.y0];
        y1  = macro[sel.y1];
        u   = macro[sel.u];
        v   = macro[sel.v];

        y0_d = $signed({24'd0, y0}) - yuvrgb_pkg::LUMA_OFFSET;
        y1_d = $signed({24'd0, y1}) - yuvrgb_pkg::LUMA_OFFSET;
        u_d  = $signed({24'd0, u}) - yuvrgb_pkg::CHROMA_OFFSET;
        v_d  = $signed({24'd0, v}) - yuvrgb_pkg::CHROMA_OFFSET;

        // All products fit comfortably in 32 signed bits
        y0_p = y0_d * yuvrgb_pkg::COEF_Y;
        y1_p = y1_d * yuvrgb_pkg::COEF_Y;
        vr_p = v_d * yuvrgb_pkg::COEF_VR;
        g_p  = v_d * yuvrgb_pkg::COEF_VG + u_d * yuvrgb_pkg::COEF_UG;
        ub_p = u_d * yuvrgb_pkg::COEF_UB;

        y0_t = yuvrgb_pkg::floor_zero(y0_p);
        y1_t = yuvrgb_pkg::floor_zero(y1_p);
        r_t  = yuvrgb_pkg::floor_zero(vr_p);
        g_t  = yuvrgb_pkg::floor_zero(g_p);
        b_t  = yuvrgb_pkg::floor_zero(ub_p);

        rgb.red_first    = yuvrgb_pkg::make_channel(y0_t, r_t);
        rgb.green_first  = yuvrgb_pkg::make_channel(y0_t, g_t);
        rgb.blue_first   = yuvrgb_pkg::make_channel(y0_t, b_t);
        rgb.red_second   = yuvrgb_pkg::make_channel(y1_t, r_t);
        rgb.green_second = yuvrgb_pkg::make_channel(y1_t, g_t);
        rgb.blue_second  = yuvrgb_pkg::make_channel(y1_t, b_t);
    end

endmodule

// ===== rtl/core/yuv422_to_rgb888_converter.sv =====
// Top level: YUV 4:2:2 macropixel to RGB888 pixel pair converter, BT.601 video range
//
// Usage
//   pix_in  : one packed macropixel per transfer (byte0..byte3 in stream order,
//             last_in marks the final macropixel of a frame).
//   pix_out : two RGB888 pixels per transfer, last_out copied from last_in.
//   cfg_we / cfg_wdata : write the byte packing (YUYV, UYVY, VYUY, YVYU, UVY2,
//             VUY2, Y2UV, Y2VU). Change it only while no transfer is in flight.
// Timing
//   Two register stages: an input register and a result register with the
//   whole conversion between them. A result is offered on pix_out from the
//   result register. Throughput is one macropixel per cycle while pix_out
//   accepts, set by the single conversion pass per item.
// Reset
//   rst_n clears both stage valid flags and sets the packing to YUYV.
// Back-pressure
//   When pix_out stalls, the result register holds and the input register
//   still takes one more item; pix_in.ready drops only once both are full.
module yuv422_to_rgb888_converter (
    input  logic               clk,
    input  logic               rst_n,
    yuvrgb_in_if.sink          pix_in,
    yuvrgb_out_if.source       pix_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_wdata
);

    logic [2:0]            order_reg;

    // Input stage
    logic                  s1_valid_reg;
    yuvrgb_pkg::macro_t    s1_macro_reg;
    logic                  s1_last_reg;

    // Result stage
    logic                  s2_valid_reg;
    yuvrgb_pkg::rgb_pair_t s2_rgb_reg;
    logic                  s2_last_reg;

    yuvrgb_pkg::rgb_pair_t rgb_next;
    logic                  s2_load;
    logic                  s1_load;

    // Result stage may take a new item when empty or being drained this cycle
    assign s2_load     = !s2_valid_reg || pix_out.ready;
    // Input stage may take a transfer when empty or when its item moves on
    assign pix_in.ready = !s1_valid_reg || s2_load;
    assign s1_load     = pix_in.valid && pix_in.ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= yuvrgb_pkg::ORDER_YUYV;
        end
        else if (cfg_we)
        begin
            order_reg <= cfg_wdata;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_in.ready)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: capture the raw bytes, hold while stalled
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_macro_reg <= {pix_in.byte3, pix_in.byte2, pix_in.byte1, pix_in.byte0};
            s1_last_reg  <= pix_in.last_in;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_rgb_reg  <= rgb_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    yuvrgb_csc u_csc (
        .macro      (s1_macro_reg),
        .order_mode (order_reg),
        .rgb        (rgb_next)
    );

    assign pix_out.valid        = s2_valid_reg;
    assign pix_out.red_first    = s2_rgb_reg.red_first;
    assign pix_out.green_first  = s2_rgb_reg.green_first;
    assign pix_out.blue_first   = s2_rgb_reg.blue_first;
    assign pix_out.red_second   = s2_rgb_reg.red_second;
    assign pix_out.green_second = s2_rgb_reg.green_second;
    assign pix_out.blue_second  = s2_rgb_reg.blue_second;
    assign pix_out.last_out     = s2_last_reg;

endmodule

// ===== rtl/core/yuvrgb_checker.sv =====
// Checker: port-level assertions for the converter, bound to the top level
module yuvrgb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red_first,
    input logic       out_last
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red_first) && $stable(out_last))
        else $error("result payload changed while stalled");

    // The pipeline never blocks input while the receiver is taking results
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // A fresh result follows an input transfer through the input and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without a matching transfer");

endmodule

bind yuv422_to_rgb888_converter yuvrgb_checker u_yuvrgb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pix_in.valid),
    .in_ready      (pix_in.ready),
    .out_valid     (pix_out.valid),
    .out_ready     (pix_out.ready),
    .out_red_first (pix_out.red_first),
    .out_last      (pix_out.last_out)
);
